FILE: rtl/core/cbsp_pkg.sv
// Shared constants and helper functions for the cubic B-spline prefilter.
// Value width, saturation helpers, register indexes and pole/gain derivation.
// No dependencies.
package cbsp_pkg;

	localparam int VAL_W = 40;
	localparam int LC_W  = 17;
	localparam int CFG_W = 9;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 40'sh7f_ffff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 40'sh80_0000_0000;

	localparam logic [1:0] CFG_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_HORIZON = 2'd2;

	function automatic logic signed [VAL_W-1:0] sat41(input logic signed [VAL_W:0] v);
		if (v[VAL_W] != v[VAL_W-1]) begin
			return v[VAL_W] ? VAL_MIN : VAL_MAX;
		end
		return v[VAL_W-1:0];
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'd1 << 62;
		x = n;
		for (int j = 0; j < 32; j++) begin
			if (b > x) b = b >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] pole_mag(input int frac);
		logic [63:0] s;
		s = isqrt64(64'd3 << (2 * frac + 2));
		return (((64'd4 << frac) - s) + 64'd1) >> 1;
	endfunction

	function automatic logic [63:0] gain_val(input int frac);
		logic [63:0] s;
		s = isqrt64(64'd3 << (2 * frac + 2));
		return (s + 64'd6) / 64'd12;
	endfunction

endpackage

FILE: rtl/core/cbsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbsp_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/cubic_bspline_prefilter_2d.sv
// Two-dimensional cubic B-spline prefilter: image store, line sequencer, shared multiplier.
// Depends on cbsp_pkg and cbsp_ram.
//
// Load items fill the image in raster order; the first load after a width change realigns
// the raster position by a bit-serial divide, unless that load starts a new image.
// The load that completes the image starts the filter pass, columns then rows, run by one
// shared multiplier, and busy stays high throughout. A read item passes through S_READ
// and gives its registered result on done; the receiver cannot stall, and results are
// never held.
module cubic_bspline_prefilter_2d
	import cbsp_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  logic signed [15:0]      sample,
	input  logic [7:0]              row,
	input  logic [7:0]              col,
	output logic                    done,
	output logic signed [31:0]      coefficient,
	output logic                    not_ready,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int LINE_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW       = $clog2(DEPTH);
	localparam int LW       = $clog2(LINE_LEN + 1);
	localparam int CIW      = $clog2(LINE_LEN);
	localparam int CW       = FRAC_BITS + 2;
	localparam int MW       = VAL_W + CW - 1;
	localparam int PH       = VAL_W / 2;
	localparam int RSH      = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int LSH      = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int RPOS     = (FRAC_BITS > 16) ? FRAC_BITS - 17 : 0;

	localparam logic [40:0]          Q16_RND = (FRAC_BITS > 16) ? (41'd1 << RPOS) : 41'd0;
	localparam logic [MW-1:0]        MUL_RND = MW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [CW-1:0] POLE_Q  = CW'(64'd0 - pole_mag(FRAC_BITS));
	localparam logic signed [CW-1:0] GAIN_Q  = CW'(gain_val(FRAC_BITS));
	localparam logic signed [CW-1:0] ONE_Q   = CW'(64'd1 << FRAC_BITS);
	localparam logic signed [47:0]   SMP_MAX = 48'sd549755813887;
	localparam logic signed [47:0]   SMP_MIN = -48'sd549755813888;
	localparam logic signed [47:0]   Q32_MAX = 48'sd2147483647;
	localparam logic signed [47:0]   Q32_MIN = -48'sd2147483648;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_DIV, S_READ, S_LINE, S_SD_RD, S_SD_MUL, S_SD_ACC, S_SD_P,
		S_C0, S_C_MUL, S_C_ADD, S_A0, S_A1, S_A2, S_A3, S_A4, S_AW, S_NEXT, S_MW
	} state_t;

	state_t                   state_q, ret_q, mul_ret;
	logic [CFG_W-1:0]         width_q, height_q, horizon_q;
	logic [LC_W-1:0]          lc_q, lc_next, dvd_q;
	logic [LC_W-1:0]          row_q;
	logic [LW-1:0]            col_q;
	logic [4:0]               div_cnt_q;
	logic                     filter_done_q, resync_q, rd_ok_q, pass_q;
	logic signed [15:0]       smp_q;
	logic [AW-1:0]            addr_q, base_q, stride, base_step, ld_addr, rd_addr, craddr;
	logic [LW-1:0]            i_q, line_q, w, h, n, k, lines;
	logic signed [VAL_W-1:0]  acc_q, prev_q, prev2_q, c_q;
	logic signed [CW-1:0]     p_q;
	logic                     done_q, not_ready_q;
	logic signed [31:0]       coeff_q;
	logic [2*LW-1:0]          wh;
	logic [LW:0]              div_r2;

	logic                     mul_go;
	logic signed [VAL_W-1:0]  mul_a;
	logic signed [CW-1:0]     mul_c;
	logic [1:0]               mph_q;
	logic [VAL_W-1:0]         mua_q;
	logic [CW-2:0]            muc_q;
	logic                     mneg_q, mdone_q;
	logic [MW-1:0]            mprod_q, mrnd;
	logic [PH+CW-2:0]         mpp;
	logic [40:0]              mmag;
	logic signed [VAL_W-1:0]  mfin, mres_q;

	logic                     cwe, lwe;
	logic [AW-1:0]            cwaddr;
	logic [VAL_W-1:0]         cwdata, crd_raw, lrd_raw;
	logic [CIW-1:0]           lwaddr, lraddr;
	logic signed [VAL_W-1:0]  crdata, lrdata, lwdata, cadd, smp_sat;
	logic signed [47:0]       smp_ext;

	function automatic logic signed [31:0] to_q16(input logic signed [VAL_W-1:0] v);
		logic [40:0]        u;
		logic signed [47:0] q;
		u = {1'b0, v[VAL_W-1] ? 40'(-v) : 40'(v)};
		if (FRAC_BITS >= 16) begin
			u = (u + Q16_RND) >> RSH;
			q = v[VAL_W-1] ? -$signed(48'(u)) : $signed(48'(u));
		end else begin
			q = 48'(v) <<< LSH;
		end
		if (q > Q32_MAX) return 32'sh7fffffff;
		if (q < Q32_MIN) return 32'sh80000000;
		return q[31:0];
	endfunction

	always_comb begin
		if (int'(width_q) > MAX_WIDTH) w = LW'(MAX_WIDTH);
		else if (width_q < 9'd2) w = LW'(2);
		else w = LW'(width_q);
		if (int'(height_q) > MAX_HEIGHT) h = LW'(MAX_HEIGHT);
		else if (height_q < 9'd2) h = LW'(2);
		else h = LW'(height_q);
		n     = pass_q ? w : h;
		lines = pass_q ? h : w;
		if (horizon_q == '0) k = LW'(1);
		else if (int'(horizon_q) > int'(n)) k = n;
		else k = LW'(horizon_q);
	end

	assign stride    = pass_q ? AW'(1) : AW'(MAX_WIDTH);
	assign base_step = pass_q ? AW'(MAX_WIDTH) : AW'(1);
	assign ld_addr   = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
	assign rd_addr   = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
	assign craddr    = (state_q == S_IDLE) ? rd_addr : addr_q;
	assign wh        = (2*LW)'(w) * (2*LW)'(h);
	assign lc_next   = lc_q + LC_W'(1);
	assign div_r2    = {col_q, dvd_q[LC_W-1]};
	assign smp_ext   = 48'(smp_q) <<< FRAC_BITS;
	assign smp_sat   = (smp_ext > SMP_MAX) ? VAL_MAX :
	                   (smp_ext < SMP_MIN) ? VAL_MIN : smp_ext[VAL_W-1:0];
	assign crdata    = $signed(crd_raw);
	assign lrdata    = $signed(lrd_raw);
	assign cadd      = sat41(41'(crdata) + 41'(mres_q));
	assign busy      = (state_q != S_IDLE);
	assign done        = done_q;
	assign coefficient = coeff_q;
	assign not_ready   = not_ready_q;

	always_comb begin
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_c   = '0;
		mul_ret = S_IDLE;
		case (state_q)
			S_SD_MUL: begin
				mul_go = 1'b1; mul_a = crdata; mul_c = p_q; mul_ret = S_SD_ACC;
			end
			S_SD_ACC: begin
				mul_go = 1'b1; mul_a = VAL_W'(p_q); mul_c = POLE_Q; mul_ret = S_SD_P;
			end
			S_C_MUL: begin
				mul_go = 1'b1; mul_a = prev_q; mul_c = POLE_Q; mul_ret = S_C_ADD;
			end
			S_A0: begin
				mul_go = 1'b1; mul_a = prev2_q; mul_c = POLE_Q; mul_ret = S_A1;
			end
			S_A1: begin
				mul_go = 1'b1; mul_a = sat41(41'(prev_q) + 41'(mres_q));
				mul_c = GAIN_Q; mul_ret = S_A2;
			end
			S_A3: begin
				mul_go = 1'b1; mul_a = sat41(41'(c_q) - 41'(lrdata));
				mul_c = POLE_Q; mul_ret = S_A4;
			end
			default: ;
		endcase
	end

	always_comb begin
		cwe    = 1'b0;
		cwaddr = addr_q;
		cwdata = mres_q;
		case (state_q)
			S_LOAD: begin
				cwe = (row_q < LC_W'(h));
				cwaddr = ld_addr;
				cwdata = smp_sat;
			end
			S_A2: cwe = 1'b1;
			S_A4: begin
				cwe = 1'b1;
				cwaddr = addr_q - stride;
			end
			default: ;
		endcase
		lwe    = (state_q == S_C0) || (state_q == S_C_ADD);
		lwaddr = (state_q == S_C0) ? '0 : CIW'(i_q);
		lwdata = (state_q == S_C0) ? acc_q : cadd;
		lraddr = CIW'(i_q - LW'(1));
	end

	cbsp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_coeff (
		.clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cwdata),
		.raddr(craddr), .rdata(crd_raw)
	);

	cbsp_ram #(.WIDTH(VAL_W), .DEPTH(LINE_LEN)) u_line (
		.clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
		.raddr(lraddr), .rdata(lrd_raw)
	);

	assign mpp  = ((mph_q == 2'd1) ? mua_q[PH-1:0] : mua_q[VAL_W-1:PH]) * muc_q;
	assign mrnd = mprod_q + MUL_RND;
	assign mmag = 41'(mrnd >> FRAC_BITS);

	always_comb begin
		if (!mneg_q) begin
			mfin = (mmag[40] | mmag[39]) ? VAL_MAX : $signed(mmag[39:0]);
		end else begin
			mfin = (mmag > 41'h80_0000_0000) ? VAL_MIN : $signed(40'(-mmag));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mph_q   <= 2'd0;
			mdone_q <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			case (mph_q)
				2'd0: begin
					if (mul_go) begin
						mph_q <= 2'd1;
					end
				end
				2'd1: mph_q <= 2'd2;
				2'd2: mph_q <= 2'd3;
				default: begin
					mph_q   <= 2'd0;
					mdone_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (mph_q)
			2'd0: begin
				if (mul_go) begin
					mua_q  <= mul_a[VAL_W-1] ? 40'(-mul_a) : 40'(mul_a);
					muc_q  <= (CW-1)'(mul_c[CW-1] ? -mul_c : mul_c);
					mneg_q <= mul_a[VAL_W-1] ^ mul_c[CW-1];
				end
			end
			2'd1: mprod_q <= MW'(mpp);
			2'd2: mprod_q <= mprod_q + (MW'(mpp) << PH);
			default: mres_q <= mfin;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			width_q       <= 9'd256;
			height_q      <= 9'd256;
			horizon_q     <= 9'd13;
			lc_q          <= '0;
			row_q         <= '0;
			col_q         <= '0;
			div_cnt_q     <= '0;
			filter_done_q <= 1'b0;
			resync_q      <= 1'b0;
			pass_q        <= 1'b0;
			line_q        <= '0;
			i_q           <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command) begin
							addr_q  <= rd_addr;
							rd_ok_q <= filter_done_q && (LW'(row) < h) && (LW'(col) < w);
							state_q <= S_READ;
						end else begin
							smp_q <= sample;
							if (filter_done_q) begin
								filter_done_q <= 1'b0;
								lc_q     <= '0;
								row_q    <= '0;
								col_q    <= '0;
								resync_q <= 1'b0;
								state_q  <= S_LOAD;
							end else if (resync_q) begin
								row_q     <= '0;
								col_q     <= '0;
								dvd_q     <= lc_q;
								div_cnt_q <= '0;
								state_q   <= S_DIV;
							end else begin
								state_q <= S_LOAD;
							end
						end
					end
				end
				S_DIV: begin
					if (div_r2 >= (LW+1)'(w)) begin
						col_q <= LW'(div_r2 - (LW+1)'(w));
						row_q <= {row_q[LC_W-2:0], 1'b1};
					end else begin
						col_q <= LW'(div_r2);
						row_q <= {row_q[LC_W-2:0], 1'b0};
					end
					dvd_q     <= dvd_q << 1;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(LC_W - 1)) begin
						resync_q <= 1'b0;
						state_q  <= S_LOAD;
					end
				end
				S_LOAD: begin
					if ((2*LW+LC_W)'(lc_next) >= (2*LW+LC_W)'(wh)) begin
						lc_q     <= '0;
						row_q    <= '0;
						col_q    <= '0;
						resync_q <= 1'b0;
						pass_q   <= 1'b0;
						line_q   <= '0;
						base_q   <= '0;
						state_q  <= S_LINE;
					end else begin
						lc_q <= lc_next;
						if (lc_next == '0) begin
							row_q <= '0;
							col_q <= '0;
						end else if (col_q == w - LW'(1)) begin
							col_q <= '0;
							row_q <= row_q + LC_W'(1);
						end else begin
							col_q <= col_q + LW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					done_q      <= 1'b1;
					coeff_q     <= rd_ok_q ? to_q16(crdata) : 32'sd0;
					not_ready_q <= !filter_done_q;
					state_q     <= S_IDLE;
				end
				S_LINE: begin
					addr_q  <= base_q;
					i_q     <= '0;
					acc_q   <= '0;
					p_q     <= ONE_Q;
					state_q <= S_SD_RD;
				end
				S_SD_RD: state_q <= S_SD_MUL;
				S_SD_MUL: begin
					ret_q   <= mul_ret;
					state_q <= S_MW;
				end
				S_SD_ACC: begin
					acc_q   <= sat41(41'(acc_q) + 41'(mres_q));
					ret_q   <= mul_ret;
					state_q <= S_MW;
				end
				S_SD_P: begin
					p_q <= CW'(mres_q);
					if (i_q + LW'(1) == k) begin
						state_q <= S_C0;
					end else begin
						i_q     <= i_q + LW'(1);
						addr_q  <= addr_q + stride;
						state_q <= S_SD_RD;
					end
				end
				S_C0: begin
					prev_q  <= acc_q;
					i_q     <= LW'(1);
					addr_q  <= base_q + stride;
					state_q <= S_C_MUL;
				end
				S_C_MUL: begin
					ret_q   <= mul_ret;
					state_q <= S_MW;
				end
				S_C_ADD: begin
					prev2_q <= prev_q;
					prev_q  <= cadd;
					if (i_q == n - LW'(1)) begin
						state_q <= S_A0;
					end else begin
						i_q     <= i_q + LW'(1);
						addr_q  <= addr_q + stride;
						state_q <= S_C_MUL;
					end
				end
				S_A0, S_A1, S_A3: begin
					ret_q   <= mul_ret;
					state_q <= S_MW;
				end
				S_A2: begin
					c_q     <= mres_q;
					state_q <= S_A3;
				end
				S_A4: begin
					c_q    <= mres_q;
					addr_q <= addr_q - stride;
					if (i_q == LW'(1)) begin
						state_q <= S_NEXT;
					end else begin
						i_q     <= i_q - LW'(1);
						state_q <= S_AW;
					end
				end
				S_AW: state_q <= S_A3;
				S_NEXT: begin
					if (line_q == lines - LW'(1)) begin
						if (!pass_q) begin
							pass_q  <= 1'b1;
							line_q  <= '0;
							base_q  <= '0;
							state_q <= S_LINE;
						end else begin
							filter_done_q <= 1'b1;
							state_q       <= S_IDLE;
						end
					end else begin
						line_q  <= line_q + LW'(1);
						base_q  <= base_q + base_step;
						state_q <= S_LINE;
					end
				end
				S_MW: begin
					if (mdone_q) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH: begin
						width_q  <= cfg_data;
						resync_q <= 1'b1;
					end
					CFG_HEIGHT:  height_q  <= cfg_data;
					CFG_HORIZON: horizon_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/cbsp_checker.sv
// Port-level checks for the cubic B-spline prefilter, bound to the top level.
// Depends on cubic_bspline_prefilter_2d.
module cbsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        command,
	input logic        done,
	input logic [31:0] coefficient,
	input logic        not_ready
);

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command |-> ##2 done)
		else $error("read item gave no result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !command |-> ##2 !done)
		else $error("load item gave a result");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && not_ready |-> coefficient == 32'd0)
		else $error("early read returned a value");

endmodule

bind cubic_bspline_prefilter_2d cbsp_checker u_cbsp_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
	.done(done), .coefficient(coefficient), .not_ready(not_ready)
);
